[hdl/http_body_chunked_decoder_top_defines.svh]
// ---------------------------------------------------------------------------
// HTTP body decoder assertion macros
// Shared property forms for the decoder's concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef HTTP_BODY_CHUNKED_DECODER_TOP_DEFINES_SVH
`define HTTP_BODY_CHUNKED_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hbcd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HBCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hbcd assertion failed");

`endif

[hdl/hbcd_pkg.sv]
// ---------------------------------------------------------------------------
// HTTP body decoder package
// Shared constants and types for the body decoder and its result queue.
// ---------------------------------------------------------------------------
package hbcd_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int LEN_BITS_DEF  = 32;

    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BODY_MODE      = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONTENT_LENGTH = 1'd1;

    localparam logic [1:0] MODE_RAW     = 2'd0;
    localparam logic [1:0] MODE_FIXED   = 2'd1;
    localparam logic [1:0] MODE_CHUNKED = 2'd2;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    localparam logic [2:0] ERR_EOF_SIZE      = 3'd0;
    localparam logic [2:0] ERR_EMPTY_SIZE    = 3'd1;
    localparam logic [2:0] ERR_NON_HEX       = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW      = 3'd3;
    localparam logic [2:0] ERR_DATA_SHORT    = 3'd4;
    localparam logic [2:0] ERR_MISSING_CRLF  = 3'd5;
    localparam logic [2:0] ERR_CONTENT_SHORT = 3'd6;

    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] error_code;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_emit;

endpackage

[hdl/hbcd_core.sv]
// ---------------------------------------------------------------------------
// HTTP body decoder core
// Holds the body state and turns each accepted transaction into up to two
// results in the same cycle.
// ---------------------------------------------------------------------------
module hbcd_core #(
    parameter int SIZE_BITS = hbcd_pkg::SIZE_BITS_DEF,
    parameter int LEN_BITS  = hbcd_pkg::LEN_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [hbcd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [hbcd_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                                i_take,
    input  logic [1:0]                          i_action,
    input  logic [7:0]                          i_data_byte,
    output hbcd_pkg::t_emit                     o_emit
);
    import hbcd_pkg::*;

    localparam int CNT_BITS = (SIZE_BITS > LEN_BITS) ? SIZE_BITS : LEN_BITS;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RAW,
        PH_FIXED,
        PH_SIZE,
        PH_DATA,
        PH_DCR,
        PH_DLF,
        PH_TRAILER
    } t_phase;

    typedef struct packed {
        logic digit;
        logic ext;
        logic gap;
        logic bad;
        logic ovf;
    } t_line_flags;

    t_phase                r_phase, n_phase;
    logic [1:0]            r_body_mode;
    logic [LEN_BITS-1:0]   r_content_length;
    logic [SIZE_BITS-1:0]  r_accum, n_accum;
    logic [CNT_BITS-1:0]   r_left, n_left;
    t_line_flags           r_flags, n_flags;
    logic                  r_tle, n_tle;
    logic                  r_cr, n_cr;
    t_emit                 emit;
    logic [4:0]            hex;
    logic                  is_space;
    logic [CNT_BITS-1:0]   left_dec;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    function automatic t_result mk(input logic [1:0] kind, input logic [7:0] b,
                                   input logic [2:0] code, input logic lst);
        t_result r;
        r.kind       = kind;
        r.out_byte   = b;
        r.error_code = code;
        r.last       = lst;
        return r;
    endfunction

    assign hex      = hex_decode(i_data_byte);
    assign is_space = (i_data_byte == CH_SP) || (i_data_byte == CH_TAB) ||
                      (i_data_byte == CH_CR) || (i_data_byte == CH_VT) ||
                      (i_data_byte == CH_FF);
    assign left_dec = r_left - CNT_BITS'(1);

    always_comb begin
        n_phase    = r_phase;
        n_accum    = r_accum;
        n_left     = r_left;
        n_flags    = r_flags;
        n_tle      = r_tle;
        n_cr       = r_cr;
        emit.count = 2'd0;
        emit.res0  = mk(KIND_PAYLOAD, 8'd0, ERR_EOF_SIZE, 1'b1);
        emit.res1  = mk(KIND_COMPLETE, 8'd0, ERR_EOF_SIZE, 1'b1);
        if (i_take) begin
            case (i_action)
                ACT_START: begin
                    n_accum = '0;
                    n_left  = '0;
                    n_flags = '0;
                    n_tle   = 1'b1;
                    n_cr    = 1'b0;
                    if (r_body_mode == MODE_CHUNKED) begin
                        n_phase = PH_SIZE;
                    end else if (r_body_mode == MODE_FIXED) begin
                        n_left = CNT_BITS'(r_content_length);
                        if (r_content_length == '0) begin
                            n_phase    = PH_IDLE;
                            emit.count = 2'd1;
                            emit.res0  = mk(KIND_COMPLETE, 8'd0, ERR_EOF_SIZE, 1'b1);
                        end else begin
                            n_phase = PH_FIXED;
                        end
                    end else begin
                        n_phase = PH_RAW;
                    end
                end
                ACT_BYTE: begin
                    case (r_phase)
                        PH_RAW: begin
                            emit.count = 2'd1;
                            emit.res0  = mk(KIND_PAYLOAD, i_data_byte, ERR_EOF_SIZE, 1'b1);
                        end
                        PH_FIXED: begin
                            n_left = left_dec;
                            if (left_dec == '0) begin
                                n_phase    = PH_IDLE;
                                emit.count = 2'd2;
                                emit.res0  = mk(KIND_PAYLOAD, i_data_byte, ERR_EOF_SIZE,
                                                1'b0);
                            end else begin
                                emit.count = 2'd1;
                                emit.res0  = mk(KIND_PAYLOAD, i_data_byte, ERR_EOF_SIZE,
                                                1'b1);
                            end
                        end
                        PH_SIZE: begin
                            if (i_data_byte == CH_LF) begin
                                if (!r_flags.digit && !r_flags.bad) begin
                                    n_phase    = PH_IDLE;
                                    emit.count = 2'd1;
                                    emit.res0  = mk(KIND_ERROR, 8'd0, ERR_EMPTY_SIZE, 1'b1);
                                end else if (r_flags.bad) begin
                                    n_phase    = PH_IDLE;
                                    emit.count = 2'd1;
                                    emit.res0  = mk(KIND_ERROR, 8'd0, ERR_NON_HEX, 1'b1);
                                end else if (r_flags.ovf) begin
                                    n_phase    = PH_IDLE;
                                    emit.count = 2'd1;
                                    emit.res0  = mk(KIND_ERROR, 8'd0, ERR_OVERFLOW, 1'b1);
                                end else begin
                                    n_flags = '0;
                                    n_accum = '0;
                                    if (r_accum == '0) begin
                                        n_phase = PH_TRAILER;
                                        n_tle   = 1'b1;
                                        n_cr    = 1'b0;
                                    end else begin
                                        n_left  = CNT_BITS'(r_accum);
                                        n_phase = PH_DATA;
                                    end
                                end
                            end else if (r_flags.ext) begin
                                n_flags = r_flags;
                            end else if (i_data_byte == CH_SEMI) begin
                                n_flags.ext = 1'b1;
                            end else if (is_space) begin
                                if (r_flags.digit || r_flags.bad) begin
                                    n_flags.gap = 1'b1;
                                end
                            end else if (!hex[4] || r_flags.gap || r_flags.bad) begin
                                n_flags.bad = 1'b1;
                            end else begin
                                if (r_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                                    n_flags.ovf = 1'b1;
                                end
                                n_accum       = {r_accum[SIZE_BITS-5:0], hex[3:0]};
                                n_flags.digit = 1'b1;
                            end
                        end
                        PH_DATA: begin
                            emit.count = 2'd1;
                            emit.res0  = mk(KIND_PAYLOAD, i_data_byte, ERR_EOF_SIZE, 1'b1);
                            n_left     = left_dec;
                            if (left_dec == '0) begin
                                n_phase = PH_DCR;
                            end
                        end
                        PH_DCR: begin
                            if (i_data_byte == CH_CR) begin
                                n_phase = PH_DLF;
                            end else begin
                                n_phase    = PH_IDLE;
                                emit.count = 2'd1;
                                emit.res0  = mk(KIND_ERROR, 8'd0, ERR_MISSING_CRLF, 1'b1);
                            end
                        end
                        PH_DLF: begin
                            if (i_data_byte == CH_LF) begin
                                n_phase = PH_SIZE;
                            end else begin
                                n_phase    = PH_IDLE;
                                emit.count = 2'd1;
                                emit.res0  = mk(KIND_ERROR, 8'd0, ERR_MISSING_CRLF, 1'b1);
                            end
                        end
                        PH_TRAILER: begin
                            if (i_data_byte == CH_LF) begin
                                if (r_tle) begin
                                    n_phase    = PH_IDLE;
                                    emit.count = 2'd1;
                                    emit.res0  = mk(KIND_COMPLETE, 8'd0, ERR_EOF_SIZE, 1'b1);
                                end else begin
                                    n_tle = 1'b1;
                                    n_cr  = 1'b0;
                                end
                            end else if (i_data_byte == CH_CR) begin
                                if (r_cr) begin
                                    n_tle = 1'b0;
                                end
                                n_cr = 1'b1;
                            end else begin
                                n_tle = 1'b0;
                                n_cr  = 1'b0;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                ACT_END: begin
                    case (r_phase)
                        PH_RAW, PH_TRAILER: begin
                            n_phase    = PH_IDLE;
                            emit.count = 2'd1;
                            emit.res0  = mk(KIND_COMPLETE, 8'd0, ERR_EOF_SIZE, 1'b1);
                        end
                        PH_FIXED: begin
                            n_phase    = PH_IDLE;
                            emit.count = 2'd1;
                            emit.res0  = mk(KIND_ERROR, 8'd0, ERR_CONTENT_SHORT, 1'b1);
                        end
                        PH_SIZE: begin
                            n_phase    = PH_IDLE;
                            emit.count = 2'd1;
                            emit.res0  = mk(KIND_ERROR, 8'd0, ERR_EOF_SIZE, 1'b1);
                        end
                        PH_DATA: begin
                            n_phase    = PH_IDLE;
                            emit.count = 2'd1;
                            emit.res0  = mk(KIND_ERROR, 8'd0, ERR_DATA_SHORT, 1'b1);
                        end
                        PH_DCR, PH_DLF: begin
                            n_phase    = PH_IDLE;
                            emit.count = 2'd1;
                            emit.res0  = mk(KIND_ERROR, 8'd0, ERR_MISSING_CRLF, 1'b1);
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_body_mode      <= MODE_RAW;
            r_content_length <= '0;
            r_accum          <= '0;
            r_left           <= '0;
            r_flags          <= '0;
            r_tle            <= 1'b1;
            r_cr             <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_left  <= n_left;
            r_flags <= n_flags;
            r_tle   <= n_tle;
            r_cr    <= n_cr;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_BODY_MODE: begin
                        r_body_mode <= i_cfg_wdata[1:0];
                    end
                    CFG_CONTENT_LENGTH: begin
                        r_content_length <= LEN_BITS'(i_cfg_wdata);
                    end
                    default: begin
                        r_body_mode <= r_body_mode;
                    end
                endcase
            end
        end
    end

    assign o_emit = emit;

endmodule

[hdl/http_body_chunked_decoder_top.sv]
// Each result is registered into the result queue and offered from its head.
// Throughput: one input transaction per cycle; the result queue holds four
// entries and input is taken while at least two are free.
// A fixed-length body's final byte yields two results, a payload and a completion.
// Reset is synchronous and active low; it empties the queue, idles the decoder
// and restores the register defaults.
// ---------------------------------------------------------------------------
// HTTP body decoder top level
// Decodes raw, fixed-length and chunked bodies and queues the results.
// ---------------------------------------------------------------------------
`include "http_body_chunked_decoder_top_defines.svh"

module http_body_chunked_decoder_top #(
    parameter int SIZE_BITS = hbcd_pkg::SIZE_BITS_DEF,
    parameter int LEN_BITS  = hbcd_pkg::LEN_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [hbcd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [hbcd_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_action,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_kind,
    output logic [7:0]                          o_out_byte,
    output logic [2:0]                          o_error_code,
    output logic                                o_last
);
    import hbcd_pkg::*;

    t_emit                  emit;
    t_result                r_q [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]  r_wr_ptr;
    logic [Q_PTR_BITS-1:0]  r_rd_ptr;
    logic [Q_CNT_BITS-1:0]  r_count, n_count;
    logic                   take;
    logic                   pop;
    t_result                head;

    assign o_ready = (r_count <= Q_CNT_BITS'(Q_DEPTH - 2));
    assign take    = i_valid && o_ready;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign n_count = r_count + Q_CNT_BITS'(emit.count) - Q_CNT_BITS'(pop);

    hbcd_core #(
        .SIZE_BITS (SIZE_BITS),
        .LEN_BITS  (LEN_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .o_emit      (emit)
    );

    always_ff @(posedge i_clk) begin
        if (emit.count != 2'd0) begin
            r_q[r_wr_ptr] <= emit.res0;
        end
        if (emit.count == 2'd2) begin
            r_q[Q_PTR_BITS'(r_wr_ptr + 1'b1)] <= emit.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= Q_PTR_BITS'(r_wr_ptr + Q_PTR_BITS'(emit.count));
            if (pop) begin
                r_rd_ptr <= Q_PTR_BITS'(r_rd_ptr + 1'b1);
            end
            r_count <= n_count;
        end
    end

    assign head         = r_q[r_rd_ptr];
    assign o_kind       = head.kind;
    assign o_out_byte   = head.out_byte;
    assign o_error_code = head.error_code;
    assign o_last       = head.last;

    `HBCD_ASSERT_NOW(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= Q_CNT_BITS'(Q_DEPTH))
    `HBCD_ASSERT_NOW(a_err_last, i_clk, i_rst_n, o_valid && (o_kind == KIND_ERROR), o_last)
    `HBCD_ASSERT_NEXT(a_more_follows, i_clk, i_rst_n, o_valid && i_ready && !o_last, o_valid)

endmodule

[verif/tb.sv]
// ---------------------------------------------------------------------------
// HTTP body decoder testbench
// Drives start, byte and end transactions through raw, fixed-length and
// chunked bodies, predicts every result in a local decoder model and checks
// each result transaction against the oldest prediction, under random
// stalls on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import hbcd_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int WD_LIMIT = 2000;

    localparam int FLG_DIGIT   = 0;
    localparam int FLG_EXT     = 1;
    localparam int FLG_GAP     = 2;
    localparam int FLG_BAD     = 3;
    localparam int FLG_OVF     = 4;
    localparam int FLG_CR_PEND = 0;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RAW, ST_FIXED, ST_SIZE, ST_DATA, ST_DCR, ST_DLF, ST_TRAILER
    } t_dec_state;

    typedef enum int {
        SZ_PLAIN, SZ_ZEROS, SZ_OVER, SZ_EMPTY, SZ_GAP, SZ_BADCH
    } t_size_flavor;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               in_action = ACT_UNUSED;
    logic [7:0]               in_byte = 8'h00;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [1:0]               out_kind;
    logic [7:0]               out_byte;
    logic [2:0]               out_err;
    logic                     out_last;

    int send_idle_pct = 22;
    int recv_idle_pct = 53;
    int n_items = 0;
    int errors = 0;
    int idle_cycles = 0;

    // Local copy of the decoder state and its registers.
    logic [1:0]               dec_mode = MODE_RAW;
    logic [LEN_BITS_DEF-1:0]  dec_len = '0;
    t_dec_state               dec_phase = ST_IDLE;
    logic [SIZE_BITS_DEF-1:0] dec_size = '0;
    logic [SIZE_BITS_DEF-1:0] dec_left = '0;
    logic [4:0]               dec_flags = '0;
    logic                     dec_trl_empty = 1'b1;

    t_result step_res[2];
    int      step_cnt;
    t_result pending[$];
    t_result mon_want;
    logic [7:0] body_bytes[$];

    http_body_chunked_decoder_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_action     (in_action),
        .i_data_byte  (in_byte),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_kind       (out_kind),
        .o_out_byte   (out_byte),
        .o_error_code (out_err),
        .o_last       (out_last)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------- decoder model ----------------

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if (c >= "0" && c <= "9") begin
            t = c - "0";
            return {1'b1, t[3:0]};
        end
        if (c >= "a" && c <= "f") begin
            t = c - "a" + 8'd10;
            return {1'b1, t[3:0]};
        end
        if (c >= "A" && c <= "F") begin
            t = c - "A" + 8'd10;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic bit is_ws(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
    endfunction

    task automatic emit(input logic [1:0] kind, input logic [7:0] b, input logic [2:0] code);
        step_res[step_cnt] = '{kind: kind, out_byte: b, error_code: code, last: 1'b0};
        step_cnt++;
    endtask

    task automatic finish_body();
        emit(KIND_COMPLETE, 8'h00, 3'd0);
        dec_phase = ST_IDLE;
    endtask

    task automatic fail_body(input logic [2:0] code);
        emit(KIND_ERROR, 8'h00, code);
        dec_phase = ST_IDLE;
    endtask

    task automatic size_line_byte(input logic [7:0] c);
        logic [4:0] hv;
        hv = hex_val(c);
        if (c == CH_LF) begin
            if (!dec_flags[FLG_DIGIT] && !dec_flags[FLG_BAD]) begin
                fail_body(ERR_EMPTY_SIZE);
            end else if (dec_flags[FLG_BAD]) begin
                fail_body(ERR_NON_HEX);
            end else if (dec_flags[FLG_OVF]) begin
                fail_body(ERR_OVERFLOW);
            end else begin
                dec_flags = '0;
                if (dec_size == 0) begin
                    dec_phase = ST_TRAILER;
                    dec_trl_empty = 1'b1;
                end else begin
                    dec_left = dec_size;
                    dec_phase = ST_DATA;
                end
                dec_size = '0;
            end
        end else if (!dec_flags[FLG_EXT]) begin
            if (c == CH_SEMI) begin
                dec_flags[FLG_EXT] = 1'b1;
            end else if (is_ws(c)) begin
                if (dec_flags[FLG_DIGIT] || dec_flags[FLG_BAD]) dec_flags[FLG_GAP] = 1'b1;
            end else if (!hv[4] || dec_flags[FLG_GAP] || dec_flags[FLG_BAD]) begin
                dec_flags[FLG_BAD] = 1'b1;
            end else begin
                if (dec_size[SIZE_BITS_DEF-1 -: 4] != 0) dec_flags[FLG_OVF] = 1'b1;
                dec_size = {dec_size[SIZE_BITS_DEF-5:0], hv[3:0]};
                dec_flags[FLG_DIGIT] = 1'b1;
            end
        end
    endtask

    task automatic trailer_byte(input logic [7:0] c);
        if (c == CH_LF) begin
            if (dec_trl_empty) begin
                finish_body();
            end else begin
                dec_trl_empty = 1'b1;
                dec_flags = '0;
            end
        end else if (c == CH_CR) begin
            if (dec_flags[FLG_CR_PEND]) dec_trl_empty = 1'b0;
            dec_flags = 5'd1;
        end else begin
            dec_trl_empty = 1'b0;
            dec_flags = '0;
        end
    endtask

    task automatic decode_step(input logic [1:0] act, input logic [7:0] c);
        t_result r;
        int i;
        step_cnt = 0;
        case (act)
            ACT_START: begin
                dec_size = '0;
                dec_left = '0;
                dec_flags = '0;
                dec_trl_empty = 1'b1;
                if (dec_mode == MODE_CHUNKED) begin
                    dec_phase = ST_SIZE;
                end else if (dec_mode == MODE_FIXED) begin
                    dec_left = dec_len;
                    if (dec_left == 0) finish_body();
                    else dec_phase = ST_FIXED;
                end else begin
                    dec_phase = ST_RAW;
                end
            end
            ACT_BYTE: begin
                case (dec_phase)
                    ST_RAW: emit(KIND_PAYLOAD, c, 3'd0);
                    ST_FIXED: begin
                        emit(KIND_PAYLOAD, c, 3'd0);
                        dec_left = dec_left - 1'b1;
                        if (dec_left == 0) finish_body();
                    end
                    ST_SIZE: size_line_byte(c);
                    ST_DATA: begin
                        emit(KIND_PAYLOAD, c, 3'd0);
                        dec_left = dec_left - 1'b1;
                        if (dec_left == 0) dec_phase = ST_DCR;
                    end
                    ST_DCR: begin
                        if (c == CH_CR) dec_phase = ST_DLF;
                        else fail_body(ERR_MISSING_CRLF);
                    end
                    ST_DLF: begin
                        if (c == CH_LF) dec_phase = ST_SIZE;
                        else fail_body(ERR_MISSING_CRLF);
                    end
                    ST_TRAILER: trailer_byte(c);
                    default: ;
                endcase
            end
            ACT_END: begin
                case (dec_phase)
                    ST_RAW, ST_TRAILER: finish_body();
                    ST_FIXED: fail_body(ERR_CONTENT_SHORT);
                    ST_SIZE: fail_body(ERR_EOF_SIZE);
                    ST_DATA: fail_body(ERR_DATA_SHORT);
                    ST_DCR, ST_DLF: fail_body(ERR_MISSING_CRLF);
                    default: ;
                endcase
            end
            default: ;
        endcase
        for (i = 0; i < step_cnt; i++) begin
            r = step_res[i];
            r.last = (i == step_cnt - 1);
            pending.push_back(r);
        end
    endtask

    // ---------------- drivers ----------------

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] c);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_byte   <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n_items++;
        decode_step(act, c);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_BODY_MODE) dec_mode = val[1:0];
        else dec_len = val;
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [31:0] len);
        wait_drained();
        write_reg(CFG_BODY_MODE, {30'd0, mode});
        write_reg(CFG_CONTENT_LENGTH, len);
    endtask

    task automatic send_body();
        send_item(ACT_START, 8'($urandom_range(0, 255)));
        foreach (body_bytes[j]) send_item(ACT_BYTE, body_bytes[j]);
    endtask

    // ---------------- stimulus builders ----------------

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10) return "0" + {4'h0, d};
        if ($urandom_range(0, 1) == 1) return "A" + {4'h0, d} - 8'd10;
        return "a" + {4'h0, d} - 8'd10;
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 4))
            0: return CH_SP;
            1: return CH_TAB;
            2: return CH_CR;
            3: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] rand_non_lf();
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= CH_LF) b = b + 8'd1;
        return b;
    endfunction

    task automatic push_hex(input logic [31:0] val, input int min_digits);
        int nd;
        int i;
        nd = 1;
        for (i = 1; i < 8; i++) begin
            if ((val >> (4 * i)) != 0) nd = i + 1;
        end
        if (min_digits > nd) nd = min_digits;
        for (i = nd - 1; i >= 0; i--) body_bytes.push_back(hex_char(val[i*4 +: 4]));
    endtask

    task automatic add_size_line(input logic [31:0] sz, input t_size_flavor flav);
        if ($urandom_range(0, 3) == 0) body_bytes.push_back(ws_char());
        case (flav)
            SZ_PLAIN: push_hex(sz, 1);
            SZ_ZEROS: begin
                repeat ($urandom_range(1, 4)) body_bytes.push_back("0");
                push_hex(sz, 1);
            end
            SZ_OVER: begin
                body_bytes.push_back(hex_char(4'($urandom_range(1, 15))));
                push_hex($urandom(), 8);
            end
            SZ_GAP: begin
                push_hex($urandom_range(1, 15), 1);
                body_bytes.push_back(ws_char());
                push_hex($urandom_range(0, 15), 1);
            end
            SZ_BADCH: begin
                if ($urandom_range(0, 1) == 1) push_hex($urandom_range(1, 255), 1);
                body_bytes.push_back(8'h67 + 8'($urandom_range(0, 19)));
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) body_bytes.push_back(ws_char());
        if ($urandom_range(0, 3) == 0) begin
            body_bytes.push_back(CH_SEMI);
            repeat ($urandom_range(0, 3)) body_bytes.push_back(rand_non_lf());
        end
        if ($urandom_range(0, 4) != 0) body_bytes.push_back(CH_CR);
        body_bytes.push_back(CH_LF);
    endtask

    task automatic build_chunked();
        int k;
        int nchunks;
        logic [31:0] sz;
        nchunks = $urandom_range(0, 3);
        for (k = 0; k < nchunks; k++) begin
            if ($urandom_range(0, 99) < 12) begin
                add_size_line('0, t_size_flavor'($urandom_range(SZ_OVER, SZ_BADCH)));
                return;
            end
            case ($urandom_range(0, 19))
                0: sz = $urandom() | 32'h0001_0000;
                1, 2: sz = $urandom_range(7, 40);
                default: sz = $urandom_range(1, 6);
            endcase
            add_size_line(sz, ($urandom_range(0, 9) == 0) ? SZ_ZEROS : SZ_PLAIN);
            if (sz > 40) begin
                repeat ($urandom_range(0, 4)) body_bytes.push_back(8'($urandom_range(0, 255)));
                return;
            end
            repeat (sz) body_bytes.push_back(8'($urandom_range(0, 255)));
            body_bytes.push_back(($urandom_range(0, 19) == 0) ?
                                 8'($urandom_range(0, 255)) : CH_CR);
            body_bytes.push_back(($urandom_range(0, 19) == 0) ?
                                 8'($urandom_range(0, 255)) : CH_LF);
        end
        add_size_line('0, ($urandom_range(0, 4) == 0) ? SZ_ZEROS : SZ_PLAIN);
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 3) == 0) begin
                body_bytes.push_back(CH_CR);
                body_bytes.push_back(CH_CR);
            end else begin
                repeat ($urandom_range(1, 5)) body_bytes.push_back(rand_non_lf());
                if ($urandom_range(0, 1) == 1) body_bytes.push_back(CH_CR);
            end
            body_bytes.push_back(CH_LF);
        end
        case ($urandom_range(0, 9))
            0: ;
            1, 2, 3, 4: body_bytes.push_back(CH_LF);
            default: begin
                body_bytes.push_back(CH_CR);
                body_bytes.push_back(CH_LF);
            end
        endcase
    endtask

    task automatic gen_body();
        int pick;
        int n;
        int cut;
        logic [31:0] len;
        bit send_end;
        if ($urandom_range(0, 1) == 1) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                set_config(($urandom_range(0, 3) == 0) ? 2'd3 : MODE_RAW, $urandom());
            end else if (pick < 6) begin
                case ($urandom_range(0, 9))
                    7: len = 32'hFFFF_FFFF;
                    8, 9: len = $urandom();
                    default: len = $urandom_range(0, 6);
                endcase
                set_config(MODE_FIXED, len);
            end else begin
                set_config(MODE_CHUNKED, $urandom());
            end
        end
        body_bytes.delete();
        send_end = ($urandom_range(0, 9) < 8);
        if (dec_mode == MODE_CHUNKED) begin
            build_chunked();
            if (body_bytes.size() > 0 && $urandom_range(0, 9) == 0)
                body_bytes[$urandom_range(0, body_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            if (body_bytes.size() > 0 && $urandom_range(0, 9) == 0) begin
                cut = $urandom_range(0, body_bytes.size() - 1);
                while (body_bytes.size() > cut) void'(body_bytes.pop_back());
            end
        end else if (dec_mode == MODE_FIXED) begin
            if (dec_len <= 8 && $urandom_range(0, 9) < 7)
                n = int'(dec_len) + (($urandom_range(0, 9) == 0) ? 2 : 0);
            else
                n = $urandom_range(0, (dec_len <= 8) ? int'(dec_len) : 6);
            repeat (n) body_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 8)) body_bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_item(ACT_START, 8'($urandom_range(0, 255)));
        foreach (body_bytes[j]) begin
            if ($urandom_range(0, 49) == 0)
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            send_item(ACT_BYTE, body_bytes[j]);
        end
        if (send_end) send_item(ACT_END, 8'($urandom_range(0, 255)));
    endtask

    // ---------------- tests ----------------

    task automatic test_raw_mode();
        set_config(MODE_RAW, 32'd0);
        send_item(ACT_END, 8'h00);
        send_item(ACT_BYTE, 8'h41);
        send_item(ACT_UNUSED, 8'hFF);
        send_item(ACT_START, 8'h00);
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_END, 8'hFF);
    endtask

    task automatic test_fixed_mode();
        set_config(MODE_FIXED, 32'd0);
        send_item(ACT_START, 8'h00);
        set_config(MODE_FIXED, 32'hFFFF_FFFF);
        send_item(ACT_START, 8'h00);
        send_item(ACT_BYTE, 8'h5A);
        send_item(ACT_END, 8'h00);
        set_config(MODE_FIXED, 32'd1);
        send_item(ACT_START, 8'h00);
        send_item(ACT_BYTE, 8'hFF);
    endtask

    task automatic test_chunked_mode();
        set_config(MODE_CHUNKED, 32'd0);
        body_bytes = '{"1", CH_SEMI, "x", CH_CR, CH_LF, "Z", CH_CR, CH_LF,
                       "0", CH_LF, CH_LF};
        send_body();
    endtask

    task automatic test_mode_three();
        set_config(2'd3, 32'd0);
        send_item(ACT_START, 8'h00);
        send_item(ACT_BYTE, 8'hA5);
        send_item(ACT_END, 8'h00);
    endtask

    task automatic test_random_bodies(input int s_pct, input int r_pct, input int quota);
        int goal;
        goal = n_items + quota;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        while (n_items < goal) gen_body();
    endtask

    // ---------------- result checking ----------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected: expected none, %s",
                         $time, "actual below");
                $display("    actual kind %0d byte %0d code %0d last %0d",
                         out_kind, out_byte, out_err, out_last);
                errors++;
            end else begin
                mon_want = pending.pop_front();
                check_field("kind", mon_want.kind, out_kind);
                check_field("out_byte", mon_want.out_byte, out_byte);
                check_field("error_code", mon_want.error_code, out_err);
                check_field("last", mon_want.last, out_last);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_raw_mode();
        test_fixed_mode();
        test_chunked_mode();
        test_mode_three();
        test_random_bodies(22, 53, 360);
        test_random_bodies(53, 22, 360);
        test_random_bodies(0, 0, 360);
        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/hbcd_pkg.sv
hdl/hbcd_core.sv
hdl/http_body_chunked_decoder_top.sv
verif/tb.sv
